### hw/rtl/cqr_pkg.sv
// Shared constants, command and status codes, and transfer types for the reversible ring queue.
package cqr_pkg;

    localparam int DEPTH  = 128;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);

    localparam logic [1:0] CMD_ENQ = 2'd0;
    localparam logic [1:0] CMD_DEQ = 2'd1;
    localparam logic [1:0] CMD_REV = 2'd2;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] entry_data;
    } t_cqr_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] popped_data;
        logic [6:0]  entry_count;
        logic [31:0] front_data;
        logic        front_valid;
    } t_cqr_out;

endpackage

### hw/rtl/circular_queue_with_reverse.sv
// Ring-buffer queue with enqueue, dequeue and in-place reversal of the held entries.
//
// A command is taken when start is high and busy is low; busy then stays high until
// the result has been formed, and the result is shown for one cycle with o_res_valid.
// The result cannot be held off, so it must be captured in that cycle. Enqueue,
// rejected commands and the unused code pass through the front read and the output
// state, dequeue adds a pop state that reads the head entry, and reverse of n held
// entries adds floor(n / 2) swap rounds: each swapped pair needs one dual read and
// two writes through the single write port of the entry store, and the front entry
// is read back from the store after every command. A new command may be started in
// the cycle the result is shown. The queue holds at most DEPTH - 1 entries.
module circular_queue_with_reverse
    import cqr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_cqr_in  i_cmd,
    output logic     busy,
    output logic     o_res_valid,
    output t_cqr_out o_res
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_POP     = 3'd1;
    localparam logic [2:0] S_REV_RD  = 3'd2;
    localparam logic [2:0] S_REV_WLO = 3'd3;
    localparam logic [2:0] S_REV_WHI = 3'd4;
    localparam logic [2:0] S_FRONT   = 3'd5;
    localparam logic [2:0] S_OUT     = 3'd6;

    logic [2:0]        r_state,  n_state;
    logic [IDX_W-1:0]  r_head,   n_head;
    logic [IDX_W-1:0]  r_tail,   n_tail;
    logic [IDX_W-1:0]  r_count,  n_count;
    logic [IDX_W-1:0]  r_lo,     n_lo;
    logic [IDX_W-1:0]  r_hi,     n_hi;
    logic [IDX_W-1:0]  r_pairs,  n_pairs;
    logic [1:0]        r_status, n_status;
    logic [DATA_W-1:0] r_popped, n_popped;
    logic              r_res_valid, n_res_valid;
    t_cqr_out          r_res,    n_res;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr_a;
    logic [IDX_W-1:0]  mem_raddr_b;
    logic [DATA_W-1:0] mem_rdata_a;
    logic [DATA_W-1:0] mem_rdata_b;

    // Shared index stepper: one increment or decrement modulo DEPTH per cycle.
    logic [IDX_W-1:0]  step_op;
    logic              step_dec;
    logic [IDX_W-1:0]  step_out;

    always_comb begin
        if (step_dec) begin
            step_out = (step_op == '0) ? IDX_W'(DEPTH - 1) : step_op - IDX_W'(1);
        end else begin
            step_out = (step_op == IDX_W'(DEPTH - 1)) ? '0 : step_op + IDX_W'(1);
        end
    end

    cqr_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (mem_re),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_pairs     = r_pairs;
        n_status    = r_status;
        n_popped    = r_popped;
        n_res_valid = 1'b0;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_waddr   = r_tail;
        mem_wdata   = i_cmd.entry_data[DATA_W-1:0];
        mem_re      = 1'b0;
        mem_raddr_a = r_head;
        mem_raddr_b = r_hi;
        step_op     = r_tail;
        step_dec    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_status = ST_DONE;
                    n_popped = '0;
                    n_state  = S_FRONT;
                    unique case (i_cmd.command)
                        CMD_ENQ: begin
                            if (r_count == IDX_W'(DEPTH - 1)) begin
                                n_status = ST_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_tail  = step_out;
                                n_count = r_count + IDX_W'(1);
                            end
                        end
                        CMD_DEQ: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                            end else begin
                                mem_re  = 1'b1;
                                n_state = S_POP;
                            end
                        end
                        CMD_REV: begin
                            // Fewer than two entries need no swap.
                            if ((r_count >> 1) != '0) begin
                                step_dec = 1'b1;
                                n_hi     = step_out;
                                n_lo     = r_head;
                                n_pairs  = r_count >> 1;
                                n_state  = S_REV_RD;
                            end
                        end
                        default: begin
                            n_state = S_FRONT;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_popped = mem_rdata_a;
                step_op  = r_head;
                n_head   = step_out;
                n_count  = r_count - IDX_W'(1);
                n_state  = S_FRONT;
            end
            S_REV_RD: begin
                mem_re      = 1'b1;
                mem_raddr_a = r_lo;
                mem_raddr_b = r_hi;
                n_state     = S_REV_WLO;
            end
            S_REV_WLO: begin
                mem_we    = 1'b1;
                mem_waddr = r_lo;
                mem_wdata = mem_rdata_b;
                step_op   = r_lo;
                n_lo      = step_out;
                n_state   = S_REV_WHI;
            end
            S_REV_WHI: begin
                mem_we    = 1'b1;
                mem_waddr = r_hi;
                mem_wdata = mem_rdata_a;
                step_op   = r_hi;
                step_dec  = 1'b1;
                n_hi      = step_out;
                n_pairs   = r_pairs - IDX_W'(1);
                n_state   = (r_pairs == IDX_W'(1)) ? S_FRONT : S_REV_RD;
            end
            S_FRONT: begin
                mem_re  = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                n_res_valid       = 1'b1;
                n_res.status      = r_status;
                n_res.popped_data = 32'(r_popped);
                n_res.entry_count = 7'(r_count);
                n_res.front_valid = (r_count != '0);
                n_res.front_data  = (r_count != '0) ? 32'(mem_rdata_a) : '0;
                n_state           = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_pairs  <= n_pairs;
        r_status <= n_status;
        r_popped <= n_popped;
        r_res    <= n_res;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef SYNTHESIS
    a_empty_matches_pointers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_head == r_tail))
        else $error("held count disagrees with head and tail pointers");

    a_start_makes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not make the block busy");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe held for more than one cycle");

    a_reverse_keeps_pointers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REV_RD || r_state == S_REV_WLO || r_state == S_REV_WHI)
        |=> ($stable(r_head) && $stable(r_tail) && $stable(r_count)))
        else $error("reversal moved head, tail or count");
`endif

endmodule

### hw/rtl/cqr_ram.sv
// Entry store: one write port and two registered read ports.
module cqr_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds when no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
